[hw/rtl/stable_priority_queue_top_assert.svh]
// Assertion macros for the stable priority queue top level.
// Expects clk and arst_n in the scope of each use.
`ifndef STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_TOP_ASSERT_SVH

// check a condition in the same cycle
`define SPQ_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// check a condition in the next cycle
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

[hw/rtl/spq_pkg.sv]
// Package for the stable priority queue: action and status codes, control struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

	localparam int COUNT_W = 5;
	localparam int VALUE_W = 32;
	localparam int PRIO_W  = 16;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_PEEK   = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef logic [COUNT_W-1:0] count_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic signed [PRIO_W-1:0] prio_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/spq_cell.sv]
// One cell of the sorted entry chain: holds a value and priority pair.
// Depends on spq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
	input  wire                      clk,
	input  wire spq_pkg::cell_ctrl_t ctrl,
	input  wire                      in_use,
	input  wire spq_pkg::value_t     new_value,
	input  wire spq_pkg::prio_t      new_prio,
	input  wire                      prev_ge,
	input  wire spq_pkg::value_t     prev_value,
	input  wire spq_pkg::prio_t      prev_prio,
	input  wire spq_pkg::value_t     next_value,
	input  wire spq_pkg::prio_t      next_prio,
	output logic                     ge,
	output spq_pkg::value_t          value_q,
	output spq_pkg::prio_t           prio_q
);

	assign ge = in_use && (prio_q >= new_prio);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (!ge) begin
				if (prev_ge) begin
					value_q <= new_value;
					prio_q  <= new_prio;
				end else begin
					value_q <= prev_value;
					prio_q  <= prev_prio;
				end
			end
		end else if (ctrl.rem) begin
			value_q <= next_value;
			prio_q  <= next_prio;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/stable_priority_queue_top.sv]
// Stable priority queue top level: cell chain, count and result register.
// Depends on spq_pkg, spq_cell and stable_priority_queue_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "stable_priority_queue_top_assert.svh"

// Entries sit in a chain of CAPACITY cells kept sorted by priority, highest
// first, equal priorities in arrival order, so the head cell is always the
// entry to serve. For each accepted action, an insert shifts the cells
// behind the insertion point up one place, a remove shifts all cells down one
// place, and the result lands in the output register on the next edge. One
// transfer is taken every cycle while the result register is free or drained
// in the same cycle. Count is reported modulo 32.
module stable_priority_queue_top #(
	parameter int CAPACITY = 16
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_stall,
	input  wire  [1:0]               action,
	input  wire  signed [31:0]       value,
	input  wire  signed [15:0]       priority_req,
	output logic                     out_valid,
	input  wire                      out_stall,
	output logic signed [31:0]       result_value,
	output logic [1:0]               status,
	output logic [4:0]               count
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [CNT_W-1:0]    count_q;
	logic                out_valid_q;
	spq_pkg::value_t     res_value_q;
	spq_pkg::status_t    status_q;
	spq_pkg::count_t     count_out_q;

	logic                in_acc;
	logic                full;
	logic                empty;
	spq_pkg::cell_ctrl_t ctrl;
	logic [CNT_W-1:0]    count_next;
	spq_pkg::value_t     res_value_next;
	spq_pkg::status_t    status_next;

	spq_pkg::value_t     cell_value [CAPACITY];
	spq_pkg::prio_t      cell_prio  [CAPACITY];
	logic [CAPACITY-1:0] cell_ge;

	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);

	always_comb begin
		ctrl           = '0;
		count_next     = count_q;
		res_value_next = '0;
		status_next    = spq_pkg::ST_OK;
		unique case (action)
			spq_pkg::ACT_INSERT: begin
				if (full) begin
					status_next = spq_pkg::ST_FULL;
				end else begin
					ctrl.ins   = in_acc;
					count_next = count_q + CNT_W'(1);
				end
			end
			spq_pkg::ACT_REMOVE: begin
				if (empty) begin
					status_next = spq_pkg::ST_EMPTY;
				end else begin
					ctrl.rem       = in_acc;
					count_next     = count_q - CNT_W'(1);
					res_value_next = cell_value[0];
				end
			end
			spq_pkg::ACT_PEEK: begin
				if (empty) begin
					status_next = spq_pkg::ST_EMPTY;
				end else begin
					res_value_next = cell_value[0];
				end
			end
			default: begin
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic            prev_ge;
		spq_pkg::value_t prev_value;
		spq_pkg::prio_t  prev_prio;
		spq_pkg::value_t next_value;
		spq_pkg::prio_t  next_prio;

		if (i == 0) begin : g_head
			assign prev_ge    = 1'b1;
			assign prev_value = cell_value[i];
			assign prev_prio  = cell_prio[i];
		end else begin : g_body
			assign prev_ge    = cell_ge[i-1];
			assign prev_value = cell_value[i-1];
			assign prev_prio  = cell_prio[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign next_value = cell_value[i];
			assign next_prio  = cell_prio[i];
		end else begin : g_inner
			assign next_value = cell_value[i+1];
			assign next_prio  = cell_prio[i+1];
		end

		spq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.in_use     (count_q > CNT_W'(i)),
			.new_value  (value),
			.new_prio   (priority_req),
			.prev_ge    (prev_ge),
			.prev_value (prev_value),
			.prev_prio  (prev_prio),
			.next_value (next_value),
			.next_prio  (next_prio),
			.ge         (cell_ge[i]),
			.value_q    (cell_value[i]),
			.prio_q     (cell_prio[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_value_q <= res_value_next;
			status_q    <= status_next;
			count_out_q <= spq_pkg::count_t'(count_next);
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = res_value_q;
	assign status       = status_q;
	assign count        = count_out_q;

	`SPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
	`SPQ_ASSERT_NEXT(a_full_drop, in_acc && (action == spq_pkg::ACT_INSERT) && full,
		out_valid && (status == spq_pkg::ST_FULL) && (count_q == $past(count_q)))
	`SPQ_ASSERT_NEXT(a_remove_count, in_acc && (action == spq_pkg::ACT_REMOVE) && !empty,
		count_q == $past(count_q) - CNT_W'(1))

endmodule

`default_nettype wire
